// ===== rtl/falu_pkg.sv =====
// Shared types, codes and widths for the fixed-point ALU.
`timescale 1ns / 1ps

package falu_pkg;

	// Number of fraction bits in the raw fixed-point format.
	localparam int FRAC_BITS = 8;

	localparam int DATA_W = 32;
	// Quotient bits produced by the divider; wider values always saturate.
	localparam int QUO_W = 33;
	// Rounded dividend 2*(|a| << FRAC_BITS) + |b| fits in this width.
	localparam int NUM_W = QUO_W + FRAC_BITS + 1;
	// Divisor 2*|b| and the partial remainder widths.
	localparam int DEN_W = 33;
	localparam int REM_W = 34;
	// Divider latency: operand prep, one stage per quotient bit, final sign stage.
	localparam int DIV_LAT = QUO_W + 2;
	// Multiplier latency before its alignment delay.
	localparam int MUL_LAT = 3;

	localparam logic [DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_LT      = 4'd4,
		OP_GT      = 4'd5,
		OP_LE      = 4'd6,
		OP_GE      = 4'd7,
		OP_EQ      = 4'd8,
		OP_NE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_DIVZ = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		UNIT_MISC = 2'd0,
		UNIT_MUL  = 2'd1,
		UNIT_DIV  = 2'd2
	} unit_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              cmp;
		err_t              err;
	} res_t;

endpackage

// ===== rtl/falu_misc.sv =====
// Combinational operations: add, subtract, compares, min, max, inc, dec, conversions.
`timescale 1ns / 1ps

module falu_misc (
	input  falu_pkg::op_t        op,
	input  logic signed [31:0]   a,
	input  logic signed [31:0]   b,
	output falu_pkg::res_t       res
);

	localparam logic [31:0] TOINT_BIAS = (32'd1 << falu_pkg::FRAC_BITS) - 32'd1;

	logic signed [32:0] sum;
	logic signed [32:0] diff;
	logic signed [32:0] incv;
	logic signed [32:0] decv;
	logic signed [63:0] scaled;
	logic        [31:0] biased;
	logic               lt;
	logic               eq;

	// Wide sums so that overflow shows in the top two bits.
	assign sum    = 33'(a) + 33'(b);
	assign diff   = 33'(a) - 33'(b);
	assign incv   = 33'(a) + 33'sd1;
	assign decv   = 33'(a) - 33'sd1;
	assign scaled = 64'(a) <<< falu_pkg::FRAC_BITS;
	assign biased = a[31] ? (32'(a) + TOINT_BIAS) : 32'(a);
	assign lt     = a < b;
	assign eq     = a == b;

	// Select the result of the requested operation, clamping where needed.
	always_comb begin
		res.value = '0;
		res.cmp   = 1'b0;
		res.err   = falu_pkg::ERR_OK;
		case (op)
			falu_pkg::OP_ADD, falu_pkg::OP_SUB, falu_pkg::OP_INC, falu_pkg::OP_DEC: begin
				logic signed [32:0] w;
				case (op)
					falu_pkg::OP_ADD: w = sum;
					falu_pkg::OP_SUB: w = diff;
					falu_pkg::OP_INC: w = incv;
					default:          w = decv;
				endcase
				if (w[32] != w[31]) begin
					res.value = w[32] ? falu_pkg::MIN_VAL : falu_pkg::MAX_VAL;
					res.err   = falu_pkg::ERR_OVF;
				end else begin
					res.value = w[31:0];
				end
			end
			falu_pkg::OP_LT: res.cmp = lt;
			falu_pkg::OP_GT: res.cmp = !lt && !eq;
			falu_pkg::OP_LE: res.cmp = lt || eq;
			falu_pkg::OP_GE: res.cmp = !lt;
			falu_pkg::OP_EQ: res.cmp = eq;
			falu_pkg::OP_NE: res.cmp = !eq;
			falu_pkg::OP_MIN: res.value = lt ? a : b;
			falu_pkg::OP_MAX: res.value = lt ? b : a;
			falu_pkg::OP_TOINT: res.value = 32'($signed(biased) >>> falu_pkg::FRAC_BITS);
			falu_pkg::OP_FROMINT: begin
				if ((scaled[63:31] != '0) && (scaled[63:31] != '1)) begin
					res.value = scaled[63] ? falu_pkg::MIN_VAL : falu_pkg::MAX_VAL;
					res.err   = falu_pkg::ERR_OVF;
				end else begin
					res.value = scaled[31:0];
				end
			end
			default: res.value = '0;
		endcase
	end

endmodule

// ===== rtl/falu_mul.sv =====
// Pipelined multiplier with round-to-nearest and saturation, aligned to the divider latency.
`timescale 1ns / 1ps

module falu_mul (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output falu_pkg::res_t     res
);

	localparam logic [63:0] MUL_HALF = (64'd1 << falu_pkg::FRAC_BITS) >> 1;
	localparam int          PAD      = falu_pkg::DIV_LAT - falu_pkg::MUL_LAT;

	logic signed [63:0] prod_s1;
	logic               neg_s1;
	logic        [63:0] mag_s2;
	logic               neg_s2;
	falu_pkg::res_t     res_s3;
	falu_pkg::res_t     pad_s [0:PAD-1];

	logic        [63:0] rounded;
	falu_pkg::res_t     res_next;

	// Stage 1: the product.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= a * b;
			neg_s1  <= a[31] ^ b[31];
		end
	end

	// Stage 2: magnitude of the product.
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: round, drop fraction bits, apply the sign with saturation.
	assign rounded = (mag_s2 + MUL_HALF) >> falu_pkg::FRAC_BITS;

	always_comb begin
		res_next.cmp = 1'b0;
		res_next.err = falu_pkg::ERR_OK;
		if (neg_s2) begin
			if (rounded > 64'h8000_0000) begin
				res_next.value = falu_pkg::MIN_VAL;
				res_next.err   = falu_pkg::ERR_OVF;
			end else begin
				res_next.value = 32'(-rounded);
			end
		end else begin
			if (rounded > 64'h7FFF_FFFF) begin
				res_next.value = falu_pkg::MAX_VAL;
				res_next.err   = falu_pkg::ERR_OVF;
			end else begin
				res_next.value = rounded[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res_next;
		end
	end

	// Delay line that lines the result up with the divider.
	always_ff @(posedge clk) begin
		if (adv) begin
			pad_s[0] <= res_s3;
			for (int i = 1; i < PAD; i++) begin
				pad_s[i] <= pad_s[i-1];
			end
		end
	end

	assign res = pad_s[PAD-1];

endmodule

// ===== rtl/falu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
`timescale 1ns / 1ps

module falu_div (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output falu_pkg::res_t     res
);

	localparam int QUO_W = falu_pkg::QUO_W;
	localparam int NUM_W = falu_pkg::NUM_W;
	localparam int DEN_W = falu_pkg::DEN_W;
	localparam int REM_W = falu_pkg::REM_W;

	typedef struct packed {
		logic neg;
		logic zero;
		logic a_pos;
		logic a_neg;
	} div_flags_t;

	logic [REM_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] num_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	div_flags_t       flg_s [0:QUO_W];
	logic             ovf_s [0:QUO_W];
	falu_pkg::res_t   out_s;

	logic [31:0]      mag_a;
	logic [31:0]      mag_b;
	logic [NUM_W-1:0] numer;
	falu_pkg::res_t   res_next;

	// Operand prep: magnitudes, rounded dividend 2*num + den, divisor 2*den.
	assign mag_a = a[31] ? 32'(-a) : 32'(a);
	assign mag_b = b[31] ? 32'(-b) : 32'(b);
	assign numer = (NUM_W'(mag_a) << (falu_pkg::FRAC_BITS + 1)) + NUM_W'(mag_b);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]       <= REM_W'(numer[NUM_W-1:QUO_W]);
			num_s[0]       <= numer[QUO_W-1:0];
			quo_s[0]       <= '0;
			den_s[0]       <= {mag_b, 1'b0};
			flg_s[0].neg   <= a[31] ^ b[31];
			flg_s[0].zero  <= (b == '0);
			flg_s[0].a_pos <= !a[31] && (a != '0);
			flg_s[0].a_neg <= a[31];
			ovf_s[0]       <= 1'b0;
		end
	end

	// One compare-and-subtract per stage; the first stage also checks that the
	// quotient fits in the quotient width.
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [REM_W-1:0] shifted;
		logic [REM_W-1:0] reduced;
		logic             ge;
		logic             ovf_now;

		assign shifted = {rem_s[k][REM_W-2:0], num_s[k][QUO_W-1-k]};
		assign ge      = shifted >= REM_W'(den_s[k]);
		assign reduced = shifted - REM_W'(den_s[k]);
		assign ovf_now = (k == 0) ? (rem_s[k] >= REM_W'(den_s[k])) : 1'b0;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? reduced : shifted;
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
				num_s[k+1] <= num_s[k];
				den_s[k+1] <= den_s[k];
				flg_s[k+1] <= flg_s[k];
				ovf_s[k+1] <= ovf_s[k] | ovf_now;
			end
		end
	end

	// Final stage: divide-by-zero handling, sign and saturation.
	always_comb begin
		res_next.cmp = 1'b0;
		res_next.err = falu_pkg::ERR_OK;
		if (flg_s[QUO_W].zero) begin
			res_next.err = falu_pkg::ERR_DIVZ;
			if (flg_s[QUO_W].a_pos) begin
				res_next.value = falu_pkg::MAX_VAL;
			end else if (flg_s[QUO_W].a_neg) begin
				res_next.value = falu_pkg::MIN_VAL;
			end else begin
				res_next.value = '0;
			end
		end else if (flg_s[QUO_W].neg) begin
			if (ovf_s[QUO_W] || (quo_s[QUO_W] > QUO_W'(33'h0_8000_0000))) begin
				res_next.value = falu_pkg::MIN_VAL;
				res_next.err   = falu_pkg::ERR_OVF;
			end else begin
				res_next.value = 32'(-quo_s[QUO_W]);
			end
		end else begin
			if (ovf_s[QUO_W] || (quo_s[QUO_W] > QUO_W'(33'h0_7FFF_FFFF))) begin
				res_next.value = falu_pkg::MAX_VAL;
				res_next.err   = falu_pkg::ERR_OVF;
			end else begin
				res_next.value = quo_s[QUO_W][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s <= res_next;
		end
	end

	assign res = out_s;

endmodule

// ===== rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed Q-format fixed-point ALU.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | operation, operand_a, operand_b
//  out     | out_valid / out_stall| result_value, compare_true, error_code
//
// One item may enter every cycle unless in_stall is high; its result is aligned
// to the divider, which resolves one quotient bit per stage.
// Reset clears only the valid bits of the pipeline; no other state is kept.
// The whole pipeline moves as one: when a result waits under out_stall, every
// stage holds and in_stall is raised, so no item is lost or repeated.
`timescale 1ns / 1ps

module fixed_point_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         operation,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output logic [1:0]         error_code
);

	localparam int LAT = falu_pkg::DIV_LAT;

	logic               adv;
	logic               valid_s [0:LAT];
	falu_pkg::op_t      op_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	falu_pkg::res_t     misc_s [0:LAT-1];
	falu_pkg::unit_t    unit_s [0:LAT-1];

	falu_pkg::res_t     misc_res;
	falu_pkg::res_t     mul_res;
	falu_pkg::res_t     div_res;
	falu_pkg::res_t     final_res;
	falu_pkg::unit_t    unit_next;

	// The pipeline advances unless a finished item is held by the receiver.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[0] <= in_valid;
			for (int i = 1; i <= LAT; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= falu_pkg::op_t'(operation);
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	falu_misc u_misc (
		.op  (op_s1),
		.a   (a_s1),
		.b   (b_s1),
		.res (misc_res)
	);

	falu_mul u_mul (
		.clk (clk),
		.adv (adv),
		.a   (a_s1),
		.b   (b_s1),
		.res (mul_res)
	);

	falu_div u_div (
		.clk (clk),
		.adv (adv),
		.a   (a_s1),
		.b   (b_s1),
		.res (div_res)
	);

	// Which unit supplies the result of this item.
	always_comb begin
		case (op_s1)
			falu_pkg::OP_MUL: unit_next = falu_pkg::UNIT_MUL;
			falu_pkg::OP_DIV: unit_next = falu_pkg::UNIT_DIV;
			default:          unit_next = falu_pkg::UNIT_MISC;
		endcase
	end

	// Delay line for the combinational results and the unit select.
	always_ff @(posedge clk) begin
		if (adv) begin
			misc_s[0] <= misc_res;
			unit_s[0] <= unit_next;
			for (int i = 1; i < LAT; i++) begin
				misc_s[i] <= misc_s[i-1];
				unit_s[i] <= unit_s[i-1];
			end
		end
	end

	// Output selection from the registered unit results.
	always_comb begin
		case (unit_s[LAT-1])
			falu_pkg::UNIT_MUL: final_res = mul_res;
			falu_pkg::UNIT_DIV: final_res = div_res;
			default:            final_res = misc_s[LAT-1];
		endcase
	end

	assign out_valid    = valid_s[LAT];
	assign result_value = final_res.value;
	assign compare_true = final_res.cmp;
	assign error_code   = final_res.err;

	// A true comparison never carries a value or an error.
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> (result_value == '0) && (error_code == falu_pkg::ERR_OK))
		else $error("comparison result carries a value or an error");

	// Divide-by-zero errors come only from the divider.
	a_divz_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == falu_pkg::ERR_DIVZ) |-> unit_s[LAT-1] == falu_pkg::UNIT_DIV)
		else $error("divide-by-zero error from a unit other than the divider");

	// An overflow always returns one of the two saturation bounds.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == falu_pkg::ERR_OVF) |->
			(result_value == falu_pkg::MAX_VAL) || (result_value == falu_pkg::MIN_VAL))
		else $error("overflow without saturated result");

endmodule

// ===== sim/fixed_point_alu_test.sv =====
// Self-checking testbench for the pipelined fixed-point ALU.
`timescale 1ns / 1ps

module fixed_point_alu_test;

	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic signed [31:0] value;
		logic               cmp;
		falu_pkg::err_t     err;
	} alu_result_t;

	// Rows of the directed table; check_fixed marks a hand-typed result.
	typedef struct {
		falu_pkg::op_t      op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit                 check_fixed;
		alu_result_t        fixed;
	} alu_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [3:0]         operation;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result_value;
	logic               compare_true;
	logic [1:0]         error_code;

	alu_result_t pending_results[$];
	int          mismatch_count;
	int          cycle_count;
	int          received_count;
	bit          hold_off_active;
	bit          quiet_receiver;

	fixed_point_alu DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.compare_true(compare_true),
		.error_code(error_code)
	);

	// Clock and cycle-count timeout.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Clamp a wide signed value to 32 bits, flagging overflow.
	function automatic void saturate(input logic signed [79:0] v,
			output logic signed [31:0] r, inout falu_pkg::err_t e);
		if (v > 80'sd2147483647) begin
			r = falu_pkg::MAX_VAL;
			e = falu_pkg::ERR_OVF;
		end else if (v < -80'sd2147483648) begin
			r = falu_pkg::MIN_VAL;
			e = falu_pkg::ERR_OVF;
		end else begin
			r = v[31:0];
		end
	endfunction

	// Expected ALU output for one operation.
	function automatic alu_result_t alu_compute(falu_pkg::op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_result_t res;
		logic signed [79:0] wa;
		logic signed [79:0] wb;
		logic signed [79:0] wide;
		logic [79:0] mag_a;
		logic [79:0] mag_b;
		logic [79:0] mag;
		bit neg;
		res.value = '0;
		res.cmp = 1'b0;
		res.err = falu_pkg::ERR_OK;
		wa = a;
		wb = b;
		mag_a = (wa < 0) ? -wa : wa;
		mag_b = (wb < 0) ? -wb : wb;
		neg = (a < 0) != (b < 0);
		case (op)
			falu_pkg::OP_ADD: saturate(wa + wb, res.value, res.err);
			falu_pkg::OP_SUB: saturate(wa - wb, res.value, res.err);
			falu_pkg::OP_MUL: begin
				mag = (mag_a * mag_b + (80'd1 << (falu_pkg::FRAC_BITS - 1)))
					>> falu_pkg::FRAC_BITS;
				wide = neg ? -$signed(mag) : $signed(mag);
				saturate(wide, res.value, res.err);
			end
			falu_pkg::OP_DIV: begin
				if (b == 0) begin
					res.err = falu_pkg::ERR_DIVZ;
					res.value = (a > 0) ? falu_pkg::MAX_VAL
						: ((a < 0) ? falu_pkg::MIN_VAL : '0);
				end else begin
					mag = (2 * (mag_a << falu_pkg::FRAC_BITS) + mag_b) / (2 * mag_b);
					wide = neg ? -$signed(mag) : $signed(mag);
					saturate(wide, res.value, res.err);
				end
			end
			falu_pkg::OP_LT: res.cmp = a < b;
			falu_pkg::OP_GT: res.cmp = a > b;
			falu_pkg::OP_LE: res.cmp = a <= b;
			falu_pkg::OP_GE: res.cmp = a >= b;
			falu_pkg::OP_EQ: res.cmp = a == b;
			falu_pkg::OP_NE: res.cmp = a != b;
			falu_pkg::OP_MIN: res.value = (a < b) ? a : b;
			falu_pkg::OP_MAX: res.value = (a < b) ? b : a;
			falu_pkg::OP_INC: saturate(wa + 1, res.value, res.err);
			falu_pkg::OP_DEC: saturate(wa - 1, res.value, res.err);
			// Truncation toward zero.
			falu_pkg::OP_TOINT: begin
				mag = mag_a >> falu_pkg::FRAC_BITS;
				wide = (a < 0) ? -$signed(mag) : $signed(mag);
				res.value = wide[31:0];
			end
			default: saturate(wa <<< falu_pkg::FRAC_BITS, res.value, res.err);
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what,
			got, want);
		mismatch_count++;
	endtask

	function automatic alu_row_t row(falu_pkg::op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_row_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		r.check_fixed = 1'b0;
		r.fixed = '0;
		return r;
	endfunction

	function automatic alu_row_t fixed_row(falu_pkg::op_t op, logic signed [31:0] a,
			logic signed [31:0] b, logic signed [31:0] v, logic c, falu_pkg::err_t e);
		alu_row_t r;
		r = row(op, a, b);
		r.check_fixed = 1'b1;
		r.fixed.value = v;
		r.fixed.cmp = c;
		r.fixed.err = e;
		return r;
	endfunction

	// Offer one item and wait until it is accepted.
	task automatic send_item(falu_pkg::op_t op, logic signed [31:0] a,
			logic signed [31:0] b, bit may_idle);
		while (may_idle && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		pending_results.push_back(alu_compute(op, a, b));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic signed [31:0] random_operand();
		case ($urandom_range(5))
			0: return falu_pkg::MAX_VAL - $urandom_range(3);
			1: return falu_pkg::MIN_VAL + $urandom_range(3);
			2: return $signed($urandom_range(4095)) - 2048;
			3: return $signed($urandom_range(65535)) <<< falu_pkg::FRAC_BITS;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, one long hold-off, and result checking.
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected item", result_value, 32'h0);
				end else begin
					alu_result_t want;
					want = pending_results.pop_front();
					if (result_value !== want.value)
						report_mismatch("result_value", result_value, want.value);
					if (compare_true !== want.cmp)
						report_mismatch("compare_true", compare_true, want.cmp);
					if (error_code !== want.err)
						report_mismatch("error_code", error_code, want.err);
				end
				received_count++;
			end
			if (hold_off_active) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_receiver && ($urandom_range(99) < 13);
			end
		end
	end

	// Long hold-off counted here while the sender keeps offering items.
	initial begin
		hold_off_active = 1'b0;
		wait (received_count >= 40);
		@(posedge clk);
		hold_off_active = 1'b1;
		repeat (120) @(posedge clk);
		hold_off_active = 1'b0;
	end

	// Stimulus: directed table, then random items.
	initial begin
		alu_row_t table_rows[$];
		alu_row_t r;
		logic signed [31:0] one;
		one = 32'sd1 <<< falu_pkg::FRAC_BITS;
		in_valid = 1'b0;
		operation = falu_pkg::OP_ADD;
		operand_a = '0;
		operand_b = '0;
		mismatch_count = 0;
		cycle_count = 0;
		received_count = 0;
		quiet_receiver = 1'b1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		table_rows.push_back(fixed_row(falu_pkg::OP_ADD, falu_pkg::MAX_VAL, 1,
			falu_pkg::MAX_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_ADD, falu_pkg::MIN_VAL, -1,
			falu_pkg::MIN_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_SUB, falu_pkg::MIN_VAL, 1,
			falu_pkg::MIN_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_SUB, 0, falu_pkg::MIN_VAL,
			falu_pkg::MAX_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_MUL, one, one, one, 0,
			falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_MUL, falu_pkg::MAX_VAL,
			falu_pkg::MAX_VAL, falu_pkg::MAX_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_MUL, falu_pkg::MIN_VAL,
			falu_pkg::MAX_VAL, falu_pkg::MIN_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(row(falu_pkg::OP_MUL, 32'sd1, 32'sd128));
		table_rows.push_back(row(falu_pkg::OP_MUL, -32'sd1, 32'sd128));
		table_rows.push_back(fixed_row(falu_pkg::OP_DIV, 5, 0, falu_pkg::MAX_VAL, 0,
			falu_pkg::ERR_DIVZ));
		table_rows.push_back(fixed_row(falu_pkg::OP_DIV, -5, 0, falu_pkg::MIN_VAL, 0,
			falu_pkg::ERR_DIVZ));
		table_rows.push_back(fixed_row(falu_pkg::OP_DIV, 0, 0, 0, 0, falu_pkg::ERR_DIVZ));
		table_rows.push_back(fixed_row(falu_pkg::OP_DIV, falu_pkg::MIN_VAL, 1,
			falu_pkg::MIN_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(row(falu_pkg::OP_DIV, 32'sd1, 32'sd3));
		table_rows.push_back(row(falu_pkg::OP_DIV, falu_pkg::MIN_VAL, -32'sd1));
		table_rows.push_back(fixed_row(falu_pkg::OP_LT, falu_pkg::MIN_VAL,
			falu_pkg::MAX_VAL, 0, 1, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_GT, falu_pkg::MIN_VAL,
			falu_pkg::MAX_VAL, 0, 0, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_LE, 7, 7, 0, 1, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_GE, 6, 7, 0, 0, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_EQ, -1, -1, 0, 1, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_NE, -1, -1, 0, 0, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_MIN, 9, 9, 9, 0, falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_MAX, falu_pkg::MIN_VAL, 3, 3, 0,
			falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_INC, falu_pkg::MAX_VAL, 0,
			falu_pkg::MAX_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_DEC, falu_pkg::MIN_VAL, 0,
			falu_pkg::MIN_VAL, 0, falu_pkg::ERR_OVF));
		table_rows.push_back(fixed_row(falu_pkg::OP_TOINT, -32'sd257, 0, -1, 0,
			falu_pkg::ERR_OK));
		table_rows.push_back(fixed_row(falu_pkg::OP_FROMINT, 32'sh0080_0000, 0,
			falu_pkg::MAX_VAL, 0, falu_pkg::ERR_OVF));

		@(posedge clk);
		// Directed rows run with an idle-free receiver.
		foreach (table_rows[i]) begin
			r = table_rows[i];
			if (r.check_fixed && alu_compute(r.op, r.a, r.b) != r.fixed)
				report_mismatch("table row", i, 0);
			send_item(r.op, r.a, r.b, 1'b0);
		end
		quiet_receiver = 1'b0;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Pause once until everything has drained.
			if (n == 250) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			quiet_receiver = (n >= 350 && n < 420);
			send_item(falu_pkg::op_t'($urandom_range(15)), random_operand(),
				random_operand(), !(n >= 350 && n < 420));
		end
		in_valid <= 1'b0;
		quiet_receiver = 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
